/* rtl/tglos_pkg.sv */
// shared constants and types for the tile grid line-of-sight block
// used by the tile store, the divider and the top level
package tglos_pkg;

	localparam int GRID_BITS      = 6;
	localparam int GRID_SIZE      = 1 << GRID_BITS;
	localparam int PLANE_BITS     = 2;
	localparam int PLANES         = 1 << PLANE_BITS;
	localparam int MAX_ACTOR_SIZE = 8;
	localparam int ADDR_W         = PLANE_BITS + 2 * GRID_BITS;
	localparam int DEPTH          = 1 << ADDR_W;
	localparam int FLAG_W         = 5;
	localparam int FRAC_BITS      = 16;
	localparam int QUOT_W         = FRAC_BITS + 1;
	localparam int POS_W          = 24;

	// flag bit positions
	localparam int FLAG_FULL  = 0;
	localparam int FLAG_NORTH = 1;
	localparam int FLAG_EAST  = 2;
	localparam int FLAG_SOUTH = 3;
	localparam int FLAG_WEST  = 4;

	// opcodes and register indexes
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;
	localparam logic [1:0] REG_SCENE_WIDTH  = 2'd0;
	localparam logic [1:0] REG_SCENE_HEIGHT = 2'd1;

	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [FLAG_W-1:0] flags_t;

	// access request from the sequencer to the tile store
	typedef struct packed {
		logic   wr_en;
		addr_t  wr_addr;
		flags_t wr_data;
		logic   rd_en;
		addr_t  rd_addr;
	} store_req_t;

endpackage

/* rtl/tglos_div.sv */
// restoring divider, one quotient bit per cycle: quot = numer * 2^16 / denom
// requires numer <= denom and denom != 0; depends on tglos_pkg
module tglos_div
	import tglos_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [5:0]        numer,
	input  logic [5:0]        denom,
	output logic              done,
	output logic [QUOT_W-1:0] quot
);

	logic [6:0]        rem_q;
	logic [5:0]        den_q;
	logic [4:0]        cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [QUOT_W-1:0] quot_q;
	logic [6:0]        trial;
	logic              ge;

	// first step compares the numerator itself, later steps shift in a zero
	always_comb begin
		trial = (cnt_q == 5'd0) ? rem_q : {rem_q[5:0], 1'b0};
		ge    = trial >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'(QUOT_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= {1'b0, numer};
			den_q  <= denom;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= ge ? (trial - {1'b0, den_q}) : trial;
			quot_q <= {quot_q[QUOT_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

/* rtl/tglos_store.sv */
// tile flag memory, one write and one registered read port, with a clearing sweep
// after reset; depends on tglos_pkg
module tglos_store
	import tglos_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  store_req_t req,
	output flags_t     rd_data,
	output logic       clr_busy
);

	flags_t mem [DEPTH];
	flags_t rd_q;
	addr_t  clr_cnt_q;
	logic   clr_busy_q;

	// clearing sweep, one entry per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q  <= '0;
			clr_busy_q <= 1'b1;
		end else if (clr_busy_q) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (clr_cnt_q == addr_t'(DEPTH - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// memory array
	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			mem[clr_cnt_q] <= '0;
		end else if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_q <= mem[req.rd_addr];
		end
	end

	assign rd_data  = rd_q;
	assign clr_busy = clr_busy_q;

endmodule

/* rtl/tile_grid_line_of_sight_top.sv */
// top level of the tile grid line-of-sight block: beat handshake, config
// registers and the query sequencer; uses tglos_pkg, tglos_store, tglos_div
//
// usage:
// - input channel (in_valid / in_stall): one beat is a write or a query.
//   a write stores tile_flags at (plane, target_y, target_x) and gives no result.
//   a query gives one beat on the output channel (out_valid / out_stall).
// - config channel (cfg_valid / cfg_ready, always ready): index 0 sets
//   scene_width, index 1 scene_height; write only while the block is idle.
// - after reset the tile store is cleared by a sweep over all 16384 entries,
//   during which in_stall stays high; config writes are taken meanwhile.
// - a write is stored as its beat is taken. a query first runs the checks, then per
//   target tile reads the store and, for a walk, runs the divider and then the
//   walk steps (one or two store reads each), and ends in the done state; at most
//   64 target tiles and up to 63 steps each. the single store read port and the
//   bit-serial divider set how long a query takes.
// - the result sits in an output register; the block takes the next beat
//   while it waits, but a following query holds before its result until the
//   receiver drops out_stall.
module tile_grid_line_of_sight_top
	import tglos_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  opcode,
	input  logic [PLANE_BITS-1:0] plane,
	input  logic [PLANE_BITS-1:0] target_plane,
	input  logic [GRID_BITS-1:0]  source_x,
	input  logic [GRID_BITS-1:0]  source_y,
	input  logic [3:0]            source_size,
	input  logic [GRID_BITS-1:0]  target_x,
	input  logic [GRID_BITS-1:0]  target_y,
	input  logic [3:0]            target_size,
	input  logic [5:0]            sight_range,
	input  logic [FLAG_W-1:0]     tile_flags,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  visible,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [1:0]            cfg_index,
	input  logic [6:0]            cfg_data
);

	typedef enum logic [3:0] {
		S_IDLE, S_CHECK, S_TILE, S_RD_SRC, S_RD_TGT, S_DIV,
		S_STEP_A, S_CHK_A, S_STEP_B, S_CHK_B, S_NEXT, S_DONE
	} state_t;

	typedef enum logic [1:0] {DIR_NORTH, DIR_EAST, DIR_SOUTH, DIR_WEST} dir_t;

	state_t     state_q;
	store_req_t sreq;
	flags_t     rd_data;
	logic       clr_busy;
	logic       accept;

	logic [6:0] scene_w_q, scene_h_q, eff_w, eff_h;

	// captured query
	logic [PLANE_BITS-1:0] plane_q, tplane_q;
	logic [5:0] sx_q, sy_q, tx_q, ty_q, range_q;
	logic [3:0] ss_q, ts_q;
	logic [2:0] i_q, j_q;

	// per-tile walk state
	logic [5:0] cx_q, cy_q, gx_q, gy_q;
	logic [6:0] ax_q, ay_q;
	logic       xneg_q, yneg_q;
	logic       major_x_q, maj_neg_q, min_neg_q;
	logic [5:0] maj_cur_q, min_cur_q, maj_tgt_q;
	logic [5:0] dst_maj_q, dst_min_q;
	dir_t       dir_q;
	flags_t     cur_flags_q;
	logic signed [POS_W-1:0] pos_q, slope_q;
	logic       vis_q;
	logic       out_valid_q, visible_q;

	// divider
	logic              div_start, div_done;
	logic [5:0]        div_num, div_den;
	logic [QUOT_W-1:0] div_quot;

	tglos_store u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (sreq),
		.rd_data  (rd_data),
		.clr_busy (clr_busy)
	);

	tglos_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.numer  (div_num),
		.denom  (div_den),
		.done   (div_done),
		.quot   (div_quot)
	);

	// handshakes
	assign in_stall  = !(state_q == S_IDLE && !clr_busy);
	assign accept    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign visible   = visible_q;

	always_comb begin
		eff_w = (scene_w_q > 7'(GRID_SIZE)) ? 7'(GRID_SIZE) : scene_w_q;
		eff_h = (scene_h_q > 7'(GRID_SIZE)) ? 7'(GRID_SIZE) : scene_h_q;
	end

	// query validity
	logic [7:0] s_end_x, s_end_y, t_end_x, t_end_y;
	logic       q_ok;
	always_comb begin
		s_end_x = {2'b0, sx_q} + {4'b0, ss_q};
		s_end_y = {2'b0, sy_q} + {4'b0, ss_q};
		t_end_x = {2'b0, tx_q} + {4'b0, ts_q};
		t_end_y = {2'b0, ty_q} + {4'b0, ts_q};
		q_ok = ss_q != 4'd0 && ss_q <= 4'(MAX_ACTOR_SIZE)
			&& ts_q != 4'd0 && ts_q <= 4'(MAX_ACTOR_SIZE)
			&& range_q != 6'd0 && plane_q == tplane_q
			&& s_end_x <= {1'b0, eff_w} && s_end_y <= {1'b0, eff_h}
			&& t_end_x <= {1'b0, eff_w} && t_end_y <= {1'b0, eff_h};
	end

	// target tile, its clamped source tile and the distances
	logic [7:0] gx, gy, s_hi_x, s_hi_y, cx, cy, ddx, ddy;
	logic [6:0] ax, ay;
	logic       adj, ox, oy, far;
	always_comb begin
		gx     = {2'b0, tx_q} + {5'b0, i_q};
		gy     = {2'b0, ty_q} + {5'b0, j_q};
		s_hi_x = s_end_x - 8'd1;
		s_hi_y = s_end_y - 8'd1;
		cx = (gx < {2'b0, sx_q}) ? {2'b0, sx_q} : ((gx > s_hi_x) ? s_hi_x : gx);
		cy = (gy < {2'b0, sy_q}) ? {2'b0, sy_q} : ((gy > s_hi_y) ? s_hi_y : gy);
		ddx = gx - cx;
		ddy = gy - cy;
		ax  = ddx[7] ? 7'(-ddx) : ddx[6:0];
		ay  = ddy[7] ? 7'(-ddy) : ddy[6:0];
		ox  = gx >= {2'b0, sx_q} && gx < s_end_x;
		oy  = gy >= {2'b0, sy_q} && gy < s_end_y;
		adj = (ox && (gy == s_end_y || gy + 8'd1 == {2'b0, sy_q}))
			|| (oy && (gx == s_end_x || gx + 8'd1 == {2'b0, sx_q}));
		far = ax > {1'b0, range_q} || ay > {1'b0, range_q}
			|| (range_q == 6'd1 && !adj);
	end

	// destination of the next walk step
	logic [7:0] fmin, d_maj, d_min, d_x, d_y;
	logic       d_in, min_inc;
	dir_t       d_dir;
	always_comb begin
		fmin    = pos_q[POS_W-1:FRAC_BITS];
		min_inc = $signed(fmin) > $signed({2'b0, min_cur_q});
		if (state_q == S_STEP_A) begin
			d_maj = maj_neg_q ? ({2'b0, maj_cur_q} - 8'd1) : ({2'b0, maj_cur_q} + 8'd1);
			d_min = {2'b0, min_cur_q};
			if (major_x_q) begin
				d_dir = maj_neg_q ? DIR_WEST : DIR_EAST;
			end else begin
				d_dir = maj_neg_q ? DIR_SOUTH : DIR_NORTH;
			end
		end else begin
			d_maj = {2'b0, maj_cur_q};
			d_min = fmin;
			if (major_x_q) begin
				d_dir = min_inc ? DIR_NORTH : DIR_SOUTH;
			end else begin
				d_dir = min_inc ? DIR_EAST : DIR_WEST;
			end
		end
		d_x  = major_x_q ? d_maj : d_min;
		d_y  = major_x_q ? d_min : d_maj;
		d_in = !d_x[7] && d_x < {1'b0, eff_w} && !d_y[7] && d_y < {1'b0, eff_h};
	end

	// wall test of a step against the tile left and the tile entered
	logic step_blocked;
	always_comb begin
		case (dir_q)
			DIR_NORTH: step_blocked = cur_flags_q[FLAG_NORTH] || rd_data[FLAG_SOUTH];
			DIR_EAST:  step_blocked = cur_flags_q[FLAG_EAST] || rd_data[FLAG_WEST];
			DIR_SOUTH: step_blocked = cur_flags_q[FLAG_SOUTH] || rd_data[FLAG_NORTH];
			DIR_WEST:  step_blocked = cur_flags_q[FLAG_WEST] || rd_data[FLAG_EAST];
			default:   step_blocked = 1'b1;
		endcase
		step_blocked = step_blocked || rd_data[FLAG_FULL];
	end

	// store requests
	always_comb begin
		sreq.wr_en   = accept && opcode == OP_WRITE;
		sreq.wr_addr = {plane, target_y, target_x};
		sreq.wr_data = tile_flags;
		sreq.rd_en   = 1'b0;
		sreq.rd_addr = {plane_q, cy[5:0], cx[5:0]};
		case (state_q)
			S_TILE: begin
				sreq.rd_en = !far;
			end
			S_RD_SRC: begin
				sreq.rd_en   = 1'b1;
				sreq.rd_addr = {plane_q, gy_q, gx_q};
			end
			S_STEP_A, S_STEP_B: begin
				sreq.rd_en   = d_in;
				sreq.rd_addr = {plane_q, d_y[5:0], d_x[5:0]};
			end
			default: begin
			end
		endcase
	end

	// divider operands: minor distance over major distance
	logic major_x;
	assign major_x   = ax_q > ay_q;
	assign div_start = state_q == S_RD_TGT && !rd_data[FLAG_FULL]
		&& !(ax_q == 7'd0 && ay_q == 7'd0);
	assign div_num   = major_x ? ay_q[5:0] : ax_q[5:0];
	assign div_den   = major_x ? ax_q[5:0] : ay_q[5:0];

	logic                 done_fire;
	logic signed [POS_W-1:0] pos_init, slope_init;
	always_comb begin
		done_fire  = state_q == S_DONE && (!out_valid_q || !out_stall);
		pos_init   = POS_W'({min_cur_q, 16'h8000}) - POS_W'(min_neg_q);
		slope_init = min_neg_q ? -POS_W'(div_quot) : POS_W'(div_quot);
	end

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scene_w_q <= 7'(GRID_SIZE);
			scene_h_q <= 7'(GRID_SIZE);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SCENE_WIDTH:  scene_w_q <= cfg_data;
				REG_SCENE_HEIGHT: scene_h_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// sequencer and registered output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			visible_q   <= 1'b0;
		end else begin
			if (done_fire) begin
				out_valid_q <= 1'b1;
				visible_q   <= vis_q;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept && opcode == OP_QUERY) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					state_q <= q_ok ? S_TILE : S_DONE;
				end
				S_TILE: begin
					state_q <= far ? S_NEXT : S_RD_SRC;
				end
				S_RD_SRC: begin
					state_q <= rd_data[FLAG_FULL] ? S_NEXT : S_RD_TGT;
				end
				S_RD_TGT: begin
					if (rd_data[FLAG_FULL]) begin
						state_q <= S_NEXT;
					end else if (ax_q == 7'd0 && ay_q == 7'd0) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_STEP_A;
					end
				end
				S_STEP_A: begin
					state_q <= d_in ? S_CHK_A : S_NEXT;
				end
				S_CHK_A: begin
					state_q <= step_blocked ? S_NEXT : S_STEP_B;
				end
				S_STEP_B: begin
					if (fmin != {2'b0, min_cur_q}) begin
						state_q <= d_in ? S_CHK_B : S_NEXT;
					end else if (maj_cur_q == maj_tgt_q) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_STEP_A;
					end
				end
				S_CHK_B: begin
					if (step_blocked) begin
						state_q <= S_NEXT;
					end else if (maj_cur_q == maj_tgt_q) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_STEP_A;
					end
				end
				S_NEXT: begin
					if ({1'b0, j_q} == ts_q - 4'd1 && {1'b0, i_q} == ts_q - 4'd1) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_TILE;
					end
				end
				S_DONE: begin
					if (done_fire) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// sequencer datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				plane_q  <= plane;
				tplane_q <= target_plane;
				sx_q     <= source_x;
				sy_q     <= source_y;
				ss_q     <= source_size;
				tx_q     <= target_x;
				ty_q     <= target_y;
				ts_q     <= target_size;
				range_q  <= sight_range;
			end
			S_CHECK: begin
				i_q   <= '0;
				j_q   <= '0;
				vis_q <= 1'b0;
			end
			S_TILE: begin
				cx_q   <= cx[5:0];
				cy_q   <= cy[5:0];
				gx_q   <= gx[5:0];
				gy_q   <= gy[5:0];
				ax_q   <= ax;
				ay_q   <= ay;
				xneg_q <= ddx[7];
				yneg_q <= ddy[7];
			end
			S_RD_SRC: begin
				cur_flags_q <= rd_data;
			end
			S_RD_TGT: begin
				major_x_q <= major_x;
				maj_cur_q <= major_x ? cx_q : cy_q;
				min_cur_q <= major_x ? cy_q : cx_q;
				maj_tgt_q <= major_x ? gx_q : gy_q;
				maj_neg_q <= major_x ? xneg_q : yneg_q;
				min_neg_q <= major_x ? yneg_q : xneg_q;
				if (!rd_data[FLAG_FULL] && ax_q == 7'd0 && ay_q == 7'd0) begin
					vis_q <= 1'b1;
				end
			end
			S_DIV: begin
				pos_q   <= pos_init;
				slope_q <= slope_init;
			end
			S_STEP_A, S_STEP_B: begin
				dst_maj_q <= d_maj[5:0];
				dst_min_q <= d_min[5:0];
				dir_q     <= d_dir;
				if (state_q == S_STEP_B && fmin == {2'b0, min_cur_q}
					&& maj_cur_q == maj_tgt_q) begin
					vis_q <= 1'b1;
				end
			end
			S_CHK_A: begin
				maj_cur_q   <= dst_maj_q;
				cur_flags_q <= rd_data;
				pos_q       <= pos_q + slope_q;
			end
			S_CHK_B: begin
				min_cur_q   <= dst_min_q;
				cur_flags_q <= rd_data;
				if (!step_blocked && maj_cur_q == maj_tgt_q) begin
					vis_q <= 1'b1;
				end
			end
			S_NEXT: begin
				if ({1'b0, j_q} == ts_q - 4'd1) begin
					j_q <= '0;
					i_q <= i_q + 3'd1;
				end else begin
					j_q <= j_q + 3'd1;
				end
			end
			default: begin
			end
		endcase
	end

	// checks on the sequencer
	a_clear_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy |-> in_stall)
		else $error("input taken during clearing sweep");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == S_DONE))
		else $error("result raised outside done state");

	a_div_only_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == S_DIV)
		else $error("divider finished outside divide state");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(visible))
		else $error("stalled result changed");

endmodule

/* verif/tile_grid_line_of_sight_top_test.sv */
`timescale 1ns / 100ps
// self-checking bench for tile_grid_line_of_sight_top: directed and random write and
// query beats, checked against a bench line-of-sight predictor; depends on tglos_pkg
module tile_grid_line_of_sight_top_test;
	import tglos_pkg::*;

	localparam int CYCLE_LIMIT = 50000000;

	typedef struct {
		logic                  opcode;
		logic [PLANE_BITS-1:0] plane;
		logic [PLANE_BITS-1:0] target_plane;
		logic [GRID_BITS-1:0]  source_x;
		logic [GRID_BITS-1:0]  source_y;
		logic [3:0]            source_size;
		logic [GRID_BITS-1:0]  target_x;
		logic [GRID_BITS-1:0]  target_y;
		logic [3:0]            target_size;
		logic [5:0]            sight_range;
		logic [FLAG_W-1:0]     tile_flags;
	} beat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid, in_stall, out_valid, out_stall, visible;
	logic cfg_valid, cfg_ready;
	logic [1:0] cfg_index;
	logic [6:0] cfg_data;
	beat_t drv_beat;

	// predictor state
	logic [FLAG_W-1:0] flag_store [PLANES][GRID_SIZE][GRID_SIZE];
	int scene_w, scene_h;
	beat_t pending_beats[$];
	logic expected_visible[$];
	int errors = 0;
	int cycles = 0;
	int accepted = 0;
	int gap_left = 0;
	int stall_left = 0;

	tile_grid_line_of_sight_top uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.opcode(drv_beat.opcode), .plane(drv_beat.plane),
		.target_plane(drv_beat.target_plane),
		.source_x(drv_beat.source_x), .source_y(drv_beat.source_y),
		.source_size(drv_beat.source_size),
		.target_x(drv_beat.target_x), .target_y(drv_beat.target_y),
		.target_size(drv_beat.target_size), .sight_range(drv_beat.sight_range),
		.tile_flags(drv_beat.tile_flags),
		.out_valid(out_valid), .out_stall(out_stall), .visible(visible),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------- predictor ----------------
	function automatic bit on_scene(int p, int x, int y);
		int ew, eh;
		ew = scene_w < GRID_SIZE ? scene_w : GRID_SIZE;
		eh = scene_h < GRID_SIZE ? scene_h : GRID_SIZE;
		return p >= 0 && p < PLANES && x >= 0 && x < ew && y >= 0 && y < eh;
	endfunction

	function automatic bit tile_solid(int p, int x, int y);
		return !on_scene(p, x, y) || flag_store[p][y][x][FLAG_FULL];
	endfunction

	// one cardinal move of the walk; position advances only when open
	function automatic bit move_open(int p, inout int cx, inout int cy, input int nx, input int ny);
		int dx, dy, sbit, dbit;
		logic [FLAG_W-1:0] ff, tf;
		dx = nx - cx;
		dy = ny - cy;
		if ((dx < 0 ? -dx : dx) + (dy < 0 ? -dy : dy) != 1)
			return 0;
		if (!on_scene(p, cx, cy) || !on_scene(p, nx, ny))
			return 0;
		ff = flag_store[p][cy][cx];
		tf = flag_store[p][ny][nx];
		if (dy == 1) begin
			sbit = FLAG_NORTH; dbit = FLAG_SOUTH;
		end else if (dx == 1) begin
			sbit = FLAG_EAST; dbit = FLAG_WEST;
		end else if (dy == -1) begin
			sbit = FLAG_SOUTH; dbit = FLAG_NORTH;
		end else begin
			sbit = FLAG_WEST; dbit = FLAG_EAST;
		end
		if (ff[sbit] || tf[dbit] || tf[FLAG_FULL])
			return 0;
		cx = nx;
		cy = ny;
		return 1;
	endfunction

	// fixed-point walk along the major axis, floor shifts and truncating slope
	function automatic bit tile_seen(int p, int sx, int sy, int tx, int ty, int rng);
		int dx, dy, ax, ay, cx, cy, pos, slope, major, stp, minor;
		dx = tx - sx;
		dy = ty - sy;
		ax = dx < 0 ? -dx : dx;
		ay = dy < 0 ? -dy : dy;
		cx = sx;
		cy = sy;
		if (tile_solid(p, sx, sy) || tile_solid(p, tx, ty))
			return 0;
		if (ax > rng || ay > rng)
			return 0;
		if (dx == 0 && dy == 0)
			return 1;
		if (ax > ay) begin
			major = sx;
			stp = dx < 0 ? -1 : 1;
			pos = sy * 65536 + 'h8000;
			slope = (dy * 65536) / ax;
			if (dy < 0)
				pos -= 1;
			while (major != tx) begin
				major += stp;
				minor = pos >>> FRAC_BITS;
				if (!move_open(p, cx, cy, major, minor))
					return 0;
				pos += slope;
				if ((pos >>> FRAC_BITS) != minor &&
						!move_open(p, cx, cy, major, pos >>> FRAC_BITS))
					return 0;
			end
		end else begin
			major = sy;
			stp = dy < 0 ? -1 : 1;
			pos = sx * 65536 + 'h8000;
			slope = (dx * 65536) / ay;
			if (dx < 0)
				pos -= 1;
			while (major != ty) begin
				major += stp;
				minor = pos >>> FRAC_BITS;
				if (!move_open(p, cx, cy, minor, major))
					return 0;
				pos += slope;
				if ((pos >>> FRAC_BITS) != minor &&
						!move_open(p, cx, cy, pos >>> FRAC_BITS, major))
					return 0;
			end
		end
		return 1;
	endfunction

	function automatic bit footprint_ok(int p, int x, int y, int sz);
		return sz > 0 && on_scene(p, x, y) && on_scene(p, x + sz - 1, y + sz - 1);
	endfunction

	function automatic bit query_visible(beat_t b);
		int sx, sy, ss, tx, ty, ts, rng, gx, gy, cx, cy;
		bit ox, oy;
		sx = b.source_x; sy = b.source_y; ss = b.source_size;
		tx = b.target_x; ty = b.target_y; ts = b.target_size;
		rng = b.sight_range;
		if (ss == 0 || ss > MAX_ACTOR_SIZE || ts == 0 || ts > MAX_ACTOR_SIZE || rng == 0 ||
				b.plane != b.target_plane || !footprint_ok(b.target_plane, tx, ty, ts) ||
				!footprint_ok(b.plane, sx, sy, ss))
			return 0;
		for (int i = 0; i < ts; i++) begin
			for (int j = 0; j < ts; j++) begin
				gx = tx + i;
				gy = ty + j;
				cx = gx < sx ? sx : (gx > sx + ss - 1 ? sx + ss - 1 : gx);
				cy = gy < sy ? sy : (gy > sy + ss - 1 ? sy + ss - 1 : gy);
				// range one only counts edge-touching tiles
				if (rng == 1) begin
					ox = gx >= sx && gx < sx + ss;
					oy = gy >= sy && gy < sy + ss;
					if (!((ox && (gy == sy + ss || gy == sy - 1)) ||
							(oy && (gx == sx + ss || gx == sx - 1))))
						continue;
				end
				if (tile_seen(b.plane, cx, cy, gx, gy, rng))
					return 1;
			end
		end
		return 0;
	endfunction

	// ---------------- stimulus helpers ----------------
	function automatic beat_t rand_beat();
		beat_t b;
		b.opcode = 1'($urandom_range(0, 1));
		b.plane = PLANE_BITS'($urandom_range(0, 3));
		b.target_plane = PLANE_BITS'($urandom_range(0, 3));
		b.source_x = GRID_BITS'($urandom_range(0, 63));
		b.source_y = GRID_BITS'($urandom_range(0, 63));
		b.source_size = 4'($urandom_range(0, 15));
		b.target_x = GRID_BITS'($urandom_range(0, 63));
		b.target_y = GRID_BITS'($urandom_range(0, 63));
		b.target_size = 4'($urandom_range(0, 15));
		b.sight_range = 6'($urandom_range(0, 63));
		b.tile_flags = FLAG_W'($urandom_range(0, 31));
		return b;
	endfunction

	function automatic beat_t wr(int p, int x, int y, int f);
		beat_t b;
		b = rand_beat();
		b.opcode = OP_WRITE;
		b.plane = PLANE_BITS'(p); b.target_x = GRID_BITS'(x); b.target_y = GRID_BITS'(y);
		b.tile_flags = FLAG_W'(f);
		return b;
	endfunction

	function automatic beat_t qry(int p, int tp, int sx, int sy, int ss, int tx, int ty,
			int ts, int rng);
		beat_t b;
		b = rand_beat();
		b.opcode = OP_QUERY;
		b.plane = PLANE_BITS'(p); b.target_plane = PLANE_BITS'(tp);
		b.source_x = GRID_BITS'(sx); b.source_y = GRID_BITS'(sy); b.source_size = 4'(ss);
		b.target_x = GRID_BITS'(tx); b.target_y = GRID_BITS'(ty); b.target_size = 4'(ts);
		b.sight_range = 6'(rng);
		return b;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if ((accepted / 128) % 3 == 0)
			return 0;
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 15);
		return $urandom_range(20, 200);
	endfunction

	// clustered traffic: wall writes and mostly small queries around one area, plus random beats
	task automatic queue_random(int count);
		int bx, by, p, r, f;
		bx = $urandom_range(0, scene_w > 24 ? (scene_w < 64 ? scene_w : 64) - 24 : 0);
		by = $urandom_range(0, scene_h > 24 ? (scene_h < 64 ? scene_h : 64) - 24 : 0);
		for (int n = 0; n < count; n++) begin
			r = $urandom_range(0, 99);
			p = $urandom_range(0, 3);
			if (r < 45) begin
				f = $urandom_range(0, 99);
				if (f < 60)
					f = 2 << $urandom_range(0, 3);
				else if (f < 80)
					f = (2 << $urandom_range(0, 3)) | (2 << $urandom_range(0, 3));
				else if (f < 88)
					f = 1 << FLAG_FULL;
				else
					f = 0;
				pending_beats.push_back(wr(p, bx + $urandom_range(0, 23),
					by + $urandom_range(0, 23), f));
			end else if (r < 90) begin
				if ($urandom_range(0, 99) < 2)
					pending_beats.push_back(qry(p, p, bx + $urandom_range(0, 16),
						by + $urandom_range(0, 16), $urandom_range(1, 8),
						bx + $urandom_range(0, 16), by + $urandom_range(0, 16),
						$urandom_range(1, 8), $urandom_range(1, 63)));
				else
					pending_beats.push_back(qry(p, p, bx + $urandom_range(0, 20),
						by + $urandom_range(0, 20), $urandom_range(1, 3),
						bx + $urandom_range(0, 20), by + $urandom_range(0, 20),
						$urandom_range(1, 3),
						$urandom_range(0, 99) < 15 ? 1 : $urandom_range(1, 12)));
			end else begin
				pending_beats.push_back(rand_beat());
			end
		end
	endtask

	task automatic wait_idle();
		while (pending_beats.size() != 0 || in_valid || expected_visible.size() != 0)
			@(negedge clk);
		repeat (50) @(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [6:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_SCENE_WIDTH)
			scene_w = val;
		else
			scene_h = val;
	endtask

	task automatic set_scene(int w, int h);
		write_reg(REG_SCENE_WIDTH, 7'(w));
		write_reg(REG_SCENE_HEIGHT, 7'(h));
	endtask

	// ---------------- driver ----------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			drv_beat <= '{default: '0};
		end else begin
			if (in_valid && !in_stall) begin
				accepted++;
				if (drv_beat.opcode == OP_WRITE)
					flag_store[drv_beat.plane][drv_beat.target_y][drv_beat.target_x] =
						drv_beat.tile_flags;
				else
					expected_visible.push_back(query_visible(drv_beat));
			end
			if (!in_valid || !in_stall) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pending_beats.size() != 0) begin
					drv_beat <= pending_beats.pop_front();
					in_valid <= 1'b1;
					gap_left = pick_gap();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ---------------- receiver stall and monitor ----------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_visible.size() == 0) begin
					$display("%0t: result beat with none expected, visible=%0b", $time, visible);
					errors++;
				end else if (expected_visible[0] !== visible) begin
					$display("%0t: visible mismatch, expected %0b actual %0b", $time,
						expected_visible[0], visible);
					errors++;
					void'(expected_visible.pop_front());
				end else begin
					void'(expected_visible.pop_front());
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
				if ((accepted / 128) % 3 != 0 && $urandom_range(0, 99) < 25)
					stall_left = $urandom_range(0, 99) < 90 ? $urandom_range(1, 4)
						: $urandom_range(20, 300);
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// ---------------- sequence ----------------
	initial begin
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		scene_w = 64;
		scene_h = 64;
		foreach (flag_store[p, y, x])
			flag_store[p][y][x] = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		set_scene(64, 64);

		// directed: adjacency, same tile, walls, invalid queries, extremes
		pending_beats.push_back(qry(0, 0, 10, 10, 1, 11, 10, 1, 1));
		pending_beats.push_back(qry(0, 0, 10, 10, 1, 11, 11, 1, 1));
		pending_beats.push_back(qry(0, 0, 5, 5, 1, 5, 5, 1, 2));
		pending_beats.push_back(qry(0, 0, 5, 5, 1, 5, 5, 1, 1));
		pending_beats.push_back(wr(0, 5, 5, 1 << FLAG_FULL));
		pending_beats.push_back(qry(0, 0, 5, 5, 1, 5, 5, 1, 2));
		pending_beats.push_back(wr(1, 20, 20, 1 << FLAG_EAST));
		pending_beats.push_back(wr(1, 23, 21, 1 << FLAG_WEST));
		pending_beats.push_back(qry(1, 1, 20, 20, 1, 22, 20, 1, 5));
		pending_beats.push_back(qry(1, 1, 24, 21, 1, 21, 22, 1, 5));
		pending_beats.push_back(qry(2, 2, 30, 30, 1, 25, 33, 1, 10));
		pending_beats.push_back(qry(2, 2, 30, 30, 2, 35, 26, 1, 10));
		pending_beats.push_back(qry(0, 0, 10, 10, 0, 12, 10, 1, 5));
		pending_beats.push_back(qry(0, 0, 10, 10, 9, 12, 10, 1, 5));
		pending_beats.push_back(qry(0, 0, 10, 10, 1, 12, 10, 15, 5));
		pending_beats.push_back(qry(0, 0, 10, 10, 1, 12, 10, 1, 0));
		pending_beats.push_back(qry(0, 1, 10, 10, 1, 12, 10, 1, 5));
		pending_beats.push_back(qry(0, 0, 60, 60, 8, 50, 50, 1, 20));
		pending_beats.push_back(qry(3, 3, 0, 0, 8, 56, 56, 8, 63));
		pending_beats.push_back(wr(3, 63, 63, 31));
		pending_beats.push_back(wr(3, 0, 0, 0));
		pending_beats.push_back(qry(3, 3, 62, 62, 1, 63, 63, 1, 1));
		pending_beats.push_back(qry(3, 3, 0, 0, 1, 0, 1, 1, 63));
		wait_idle();

		// random phases across scene settings, extremes included
		queue_random(480);
		wait_idle();
		set_scene(127, 40);
		queue_random(300);
		wait_idle();
		set_scene(13, 64);
		queue_random(300);
		wait_idle();
		set_scene(1, 1);
		queue_random(100);
		wait_idle();
		set_scene(0, 5);
		queue_random(50);
		wait_idle();
		set_scene(64, 9);
		queue_random(250);
		wait_idle();

		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
